### design/mdtp_pkg.sv
// mdtp_pkg: shared types, constants and decode functions for the midi drum track parser
// no dependencies; imported by every other design file
`timescale 1ns / 1ps

package mdtp_pkg;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] ST_META    = 8'hFF;
  localparam logic [7:0] ST_CTRL    = 8'hB9;
  localparam logic [7:0] ST_PROG    = 8'hC9;
  localparam logic [7:0] ST_NOTE_ON = 8'h99;

  localparam logic [3:0]  HDR_TPQN_HI = 4'd12;
  localparam logic [3:0]  HDR_TPQN_LO = 4'd13;
  localparam logic [3:0]  FIELD_LAST  = 4'd3;
  localparam logic [31:0] DELTA_SHIFT_MAX = 32'h01FF_FFFF;
  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
  localparam logic [7:0]  TEMPO_RESET = 8'd100;

  localparam logic KIND_HIT = 1'b0;
  localparam logic KIND_ERR = 1'b1;

  typedef enum logic [3:0] {
    PH_HDR, PH_SIG, PH_LEN, PH_DELTA, PH_EVENT, PH_MTYPE, PH_MLEN,
    PH_MSKIP, PH_CTRL1, PH_CTRL2, PH_KEY, PH_VEL, PH_HALT
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE, BK_MUL, BK_CHK, BK_DIV, BK_WAIT
  } back_state_t;

  // one job handed from the parser to the time converter
  typedef struct packed {
    logic        kind;
    logic [7:0]  note;
    logic [31:0] ticks;
  } job_t;

  function automatic logic [7:0] sig_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h4D;
      2'd1:    c = 8'h54;
      2'd2:    c = 8'h72;
      default: c = 8'h6B;
    endcase
    return c;
  endfunction

  function automatic logic [3:0] drum_map(input logic [7:0] n);
    logic [3:0] d;
    case (n)
      8'd38:                d = 4'd1;
      8'd41:                d = 4'd2;
      8'd45:                d = 4'd3;
      8'd47, 8'd48, 8'd50:  d = 4'd4;
      8'd42:                d = 4'd5;
      8'd51:                d = 4'd6;
      8'd49:                d = 4'd7;
      8'd57:                d = 4'd8;
      8'd36:                d = 4'd10;
      8'd46:                d = 4'd11;
      default:              d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

### design/mdtp_front.sv
// mdtp_front: byte parser for header, track chunks, delta times and events
// depends on mdtp_pkg; pushes hit and error jobs into mdtp_queue
`timescale 1ns / 1ps

module mdtp_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_fire,
  input  logic [7:0]     data_byte,
  input  logic           q_full,
  output logic           in_ready,
  output logic           push,
  output mdtp_pkg::job_t push_job,
  output logic [15:0]    tpqn
);
  import mdtp_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  field_count, field_count_next;
  logic [15:0] tpqn_q, tpqn_next;
  logic [31:0] track_left, track_left_next;
  logic [31:0] delta, delta_next;
  logic [31:0] tick_total, tick_total_next;
  logic [7:0]  run_status, run_status_next;
  logic [7:0]  meta_left, meta_left_next;
  logic [7:0]  held_note, held_note_next;

  logic [31:0] d_src, d_shift, len_shift;
  logic [32:0] tick_sum;
  logic [31:0] tick_sat;
  logic        is_status, sig_bad, in_track, track_end;

  assign in_ready  = !q_full;
  assign is_status = (data_byte == ST_META) || (data_byte == ST_CTRL) ||
                     (data_byte == ST_PROG) || (data_byte == ST_NOTE_ON);
  assign sig_bad   = data_byte != sig_char(field_count[1:0]);
  assign len_shift = {track_left[23:0], data_byte};
  assign in_track  = (phase != PH_HDR) && (phase != PH_SIG) &&
                     (phase != PH_LEN) && (phase != PH_HALT);
  assign track_end = in_fire && in_track && (track_left <= 32'd1);

  // a data byte with no running status starts a fresh delta
  assign d_src    = (phase == PH_DELTA) ? delta : '0;
  assign d_shift  = (d_src > DELTA_SHIFT_MAX) ? '1 : {d_src[24:0], data_byte[6:0]};
  assign tick_sum = {1'b0, tick_total} + {1'b0, d_shift};
  assign tick_sat = tick_sum[32] ? '1 : tick_sum[31:0];

  assign tpqn = tpqn_q;

  always_comb begin
    phase_next = phase;
    if (in_fire) begin
      unique case (phase)
        PH_HDR:   if (field_count >= HDR_TPQN_LO) phase_next = PH_SIG;
        PH_SIG: begin
          if (sig_bad) phase_next = PH_HALT;
          else if (field_count >= FIELD_LAST) phase_next = PH_LEN;
        end
        PH_LEN: begin
          if (field_count >= FIELD_LAST)
            phase_next = (len_shift == '0) ? PH_SIG : PH_DELTA;
        end
        PH_DELTA: phase_next = data_byte[7] ? PH_DELTA : PH_EVENT;
        PH_EVENT: begin
          if (is_status) begin
            if (data_byte == ST_META) phase_next = PH_MTYPE;
            else if (data_byte == ST_NOTE_ON) phase_next = PH_KEY;
            else phase_next = PH_CTRL1;
          end else begin
            unique case (run_status)
              ST_META:    phase_next = PH_MLEN;
              ST_CTRL:    phase_next = PH_CTRL2;
              ST_PROG:    phase_next = PH_DELTA;
              ST_NOTE_ON: phase_next = PH_VEL;
              default:    phase_next = data_byte[7] ? PH_DELTA : PH_EVENT;
            endcase
          end
        end
        PH_MTYPE: phase_next = PH_MLEN;
        PH_MLEN:  phase_next = (data_byte == 8'd0) ? PH_DELTA : PH_MSKIP;
        PH_MSKIP: if (meta_left == 8'd1) phase_next = PH_DELTA;
        PH_CTRL1: phase_next = (run_status == ST_CTRL) ? PH_CTRL2 : PH_DELTA;
        PH_CTRL2: phase_next = PH_DELTA;
        PH_KEY:   phase_next = PH_VEL;
        PH_VEL:   phase_next = PH_DELTA;
        PH_HALT:  phase_next = PH_HALT;
        default:  phase_next = PH_HALT;
      endcase
      if (track_end) phase_next = PH_SIG;
    end
  end

  always_comb begin
    field_count_next = field_count;
    tpqn_next        = tpqn_q;
    track_left_next  = track_left;
    delta_next       = delta;
    tick_total_next  = tick_total;
    run_status_next  = run_status;
    meta_left_next   = meta_left;
    held_note_next   = held_note;
    push             = 1'b0;
    push_job.kind    = KIND_HIT;
    push_job.note    = held_note;
    push_job.ticks   = tick_total;
    if (in_fire) begin
      unique case (phase)
        PH_HDR: begin
          if (field_count == HDR_TPQN_HI) tpqn_next = {data_byte, 8'd0};
          else if (field_count == HDR_TPQN_LO) tpqn_next = {tpqn_q[15:8], data_byte};
          field_count_next = (field_count >= HDR_TPQN_LO) ? 4'd0 : field_count + 4'd1;
        end
        PH_SIG: begin
          if (sig_bad) begin
            push           = 1'b1;
            push_job.kind  = KIND_ERR;
            push_job.note  = '0;
            push_job.ticks = '0;
          end else if (field_count >= FIELD_LAST) begin
            field_count_next = '0;
            track_left_next  = '0;
          end else begin
            field_count_next = field_count + 4'd1;
          end
        end
        PH_LEN: begin
          track_left_next = len_shift;
          if (field_count >= FIELD_LAST) begin
            field_count_next = '0;
            tick_total_next  = '0;
            delta_next       = '0;
          end else begin
            field_count_next = field_count + 4'd1;
          end
        end
        PH_DELTA: begin
          delta_next = d_shift;
          if (!data_byte[7]) tick_total_next = tick_sat;
        end
        PH_EVENT: begin
          if (is_status) begin
            run_status_next = data_byte;
          end else begin
            unique case (run_status)
              ST_META, ST_CTRL: ;
              ST_PROG:    delta_next = '0;
              ST_NOTE_ON: held_note_next = data_byte;
              default: begin
                delta_next = d_shift;
                if (!data_byte[7]) tick_total_next = tick_sat;
              end
            endcase
          end
        end
        PH_MTYPE: ;
        PH_MLEN: begin
          meta_left_next = data_byte;
          if (data_byte == 8'd0) delta_next = '0;
        end
        PH_MSKIP: begin
          meta_left_next = meta_left - 8'd1;
          if (meta_left == 8'd1) delta_next = '0;
        end
        PH_CTRL1: if (run_status != ST_CTRL) delta_next = '0;
        PH_CTRL2: delta_next = '0;
        PH_KEY:   held_note_next = data_byte;
        PH_VEL: begin
          delta_next = '0;
          if (data_byte != 8'd0) begin
            push            = 1'b1;
            tick_total_next = '0;
          end
        end
        PH_HALT: ;
        default: ;
      endcase
      if (in_track && track_left != '0) track_left_next = track_left - 32'd1;
      if (track_end) field_count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HDR;
      field_count <= '0;
      tpqn_q      <= '0;
      track_left  <= '0;
      delta       <= '0;
      tick_total  <= '0;
      run_status  <= '0;
      meta_left   <= '0;
      held_note   <= '0;
    end else begin
      phase       <= phase_next;
      field_count <= field_count_next;
      tpqn_q      <= tpqn_next;
      track_left  <= track_left_next;
      delta       <= delta_next;
      tick_total  <= tick_total_next;
      run_status  <= run_status_next;
      meta_left   <= meta_left_next;
      held_note   <= held_note_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("parser left halt");

  a_err_from_sig: assert property (@(posedge clk) disable iff (rst)
    push && push_job.kind == KIND_ERR |-> phase == PH_SIG && phase_next == PH_HALT)
    else $error("error job outside signature check");

  a_fc_range: assert property (@(posedge clk) disable iff (rst)
    field_count <= HDR_TPQN_LO)
    else $error("field count out of range");
`endif

endmodule

### design/mdtp_queue.sv
// mdtp_queue: short job queue between the parser and the time converter
// depends on mdtp_pkg for job_t and the queue depth
`timescale 1ns / 1ps

module mdtp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mdtp_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           q_valid,
  output mdtp_pkg::job_t head
);
  import mdtp_pkg::*;

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push, do_pop;

  assign full    = count == (QPTR_W+1)'(QDEPTH);
  assign q_valid = count != '0;
  assign head    = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= (QPTR_W+1)'(QDEPTH))
    else $error("queue count past depth");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push && !pop |-> !full)
    else $error("push into full queue");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + (QPTR_W+1)'(1))
    else $error("queue count did not follow push");
`endif

endmodule

### design/mdtp_back.sv
// mdtp_back: converts ticks to milliseconds with a bit-serial divider, holds the result
// depends on mdtp_pkg; takes jobs from mdtp_queue
`timescale 1ns / 1ps

module mdtp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  mdtp_pkg::job_t head,
  input  logic [7:0]     tempo,
  input  logic [15:0]    tpqn,
  input  logic           out_ready,
  output logic           pop,
  output logic           out_valid,
  output logic           kind,
  output logic [3:0]     drum_code,
  output logic [7:0]     note_number,
  output logic [31:0]    time_ms
);
  import mdtp_pkg::*;

  back_state_t state, state_next;
  job_t        job;
  logic [47:0] dividend;
  logic [23:0] divisor;
  logic [23:0] rem;
  logic [31:0] quo;
  logic [4:0]  step;
  logic [31:0] result;
  logic        load_out, slot_free, overflow;
  logic [24:0] trial;

  assign slot_free = !out_valid || out_ready;
  // quotient needs more than 32 bits once the upper dividend reaches the divisor; a zero divisor is flagged too
  assign overflow  = (divisor == '0) || (dividend[47:32] >= divisor);
  assign trial     = {rem, quo[31]} - {1'b0, divisor};

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = (head.kind == KIND_ERR) ? BK_WAIT : BK_MUL;
      BK_MUL:  state_next = BK_CHK;
      BK_CHK:  state_next = overflow ? BK_WAIT : BK_DIV;
      BK_DIV:  if (step == 5'd31) state_next = BK_WAIT;
      BK_WAIT: if (slot_free) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    load_out = 1'b0;
    unique case (state)
      BK_IDLE: pop = q_valid;
      BK_WAIT: load_out = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      BK_IDLE: begin
        job    <= head;
        result <= '0;
      end
      BK_MUL: begin
        dividend <= 48'(job.ticks) * 48'(MS_PER_MINUTE);
        divisor  <= 24'(tempo) * 24'(tpqn);
      end
      BK_CHK: begin
        result <= '1;
        rem    <= {8'd0, dividend[47:32]};
        quo    <= dividend[31:0];
        step   <= '0;
      end
      BK_DIV: begin
        if (!trial[24]) rem <= trial[23:0];
        else rem <= {rem[22:0], quo[31]};
        quo  <= {quo[30:0], !trial[24]};
        step <= step + 5'd1;
        if (step == 5'd31) result <= {quo[30:0], !trial[24]};
      end
      BK_WAIT: begin
        if (load_out) begin
          kind        <= job.kind;
          drum_code   <= (job.kind == KIND_ERR) ? 4'd0 : drum_map(job.note);
          note_number <= job.note;
          time_ms     <= result;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    state == BK_DIV |-> rem < divisor)
    else $error("divider remainder not below divisor");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    load_out |=> out_valid)
    else $error("loaded result not presented");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_ERR |-> drum_code == '0 && note_number == '0 && time_ms == '0)
    else $error("error result carries data");
`endif

endmodule

### design/midi_drum_track_parser.sv
// midi_drum_track_parser: top level, tempo register plus parser, job queue and converter
// depends on mdtp_pkg, mdtp_front, mdtp_queue, mdtp_back
`timescale 1ns / 1ps

// Takes a standard MIDI file one byte per transfer and returns one result per
// drum note-on (kind 0) or one result for a bad track signature (kind 1, after
// which every byte is taken and ignored until reset). The parser takes a byte
// every cycle while its two-entry job queue has room; each hit then passes
// through the converter in order: a pop, a multiply, an overflow check, 32
// steps of the bit-serial divider and a load of the output register, so hits
// that come faster than the converter drains them stall input once the queue
// fills. Error results skip the divider. tempo_bpm is written through
// cfg_valid/cfg_data and must only change while no result is pending.
module midi_drum_track_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [3:0]  drum_code,
  output logic [7:0]  note_number,
  output logic [31:0] time_ms
);
  import mdtp_pkg::*;

  logic [7:0]  tempo_bpm;
  logic [15:0] tpqn;
  logic        in_fire, push, pop, q_full, q_valid;
  job_t        push_job, head;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) tempo_bpm <= TEMPO_RESET;
    else if (cfg_valid) tempo_bpm <= cfg_data;
  end

  mdtp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .data_byte(data_byte),
    .q_full   (q_full),
    .in_ready (in_ready),
    .push     (push),
    .push_job (push_job),
    .tpqn     (tpqn)
  );

  mdtp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .full    (q_full),
    .q_valid (q_valid),
    .head    (head)
  );

  mdtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .head       (head),
    .tempo      (tempo_bpm),
    .tpqn       (tpqn),
    .out_ready  (out_ready),
    .pop        (pop),
    .out_valid  (out_valid),
    .kind       (kind),
    .drum_code  (drum_code),
    .note_number(note_number),
    .time_ms    (time_ms)
  );

endmodule

### tb/tb_midi_drum_track_parser.sv
// tb_midi_drum_track_parser: self-checking testbench for the midi drum track parser
// streams MIDI file bytes through the byte channel and checks every hit and error result
// depends on mdtp_pkg and midi_drum_track_parser
`timescale 1ns / 1ps

module tb_midi_drum_track_parser;
  import mdtp_pkg::*;

  localparam int ITEM_GOAL     = 1700;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int DRAIN_CYCLES  = 100;
  localparam logic [31:0] TRACK_TAG = 32'h4D54_726B;

  typedef struct packed {
    logic        kind;
    logic [3:0]  code;
    logic [7:0]  note;
    logic [31:0] ms;
  } drum_event_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_LONG} rx_mode_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [3:0]  drum_code;
  logic [7:0]  note_number;
  logic [31:0] time_ms;

  // parser state mirrored by the predictor
  phase_t      ph;
  logic [3:0]  fld_cnt;
  logic [15:0] tpqn;
  logic [31:0] trk_left;
  logic [31:0] vlq_acc;
  logic [31:0] ticks;
  logic [7:0]  run_status;
  logic [7:0]  meta_left;
  logic [7:0]  key_note;
  logic [7:0]  tempo_now;

  drum_event_t hits_due[$];
  drum_event_t want;
  logic [7:0]  byte_queue[$];
  logic [7:0]  track_body[$];
  logic [7:0]  gen_status = 8'd0;

  int queued_total = 0;
  int taken_total = 0;
  int hit_total = 0;
  int error_total = 0;
  int mismatch_count = 0;
  int tempo_writes = 0;
  int cycle_count = 0;

  logic byte_taken = 1'b0;
  logic cfg_taken = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int mode_left = 0;
  int stall_left = 0;

  midi_drum_track_parser dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .drum_code(drum_code),
    .note_number(note_number),
    .time_ms(time_ms)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [3:0] drum_of(input logic [7:0] n);
    logic [3:0] d;
    d = 4'd0;
    case (n)
      8'd36: d = 4'd10;
      8'd38: d = 4'd1;
      8'd41: d = 4'd2;
      8'd42: d = 4'd5;
      8'd45: d = 4'd3;
      8'd46: d = 4'd11;
      8'd47, 8'd48, 8'd50: d = 4'd4;
      8'd49: d = 4'd7;
      8'd51: d = 4'd6;
      8'd57: d = 4'd8;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

  task automatic start_delta();
    vlq_acc = 32'd0;
    ph = PH_DELTA;
  endtask

  task automatic take_vlq_byte(input logic [7:0] b);
    logic [31:0] sum;
    if (vlq_acc > DELTA_SHIFT_MAX) vlq_acc = '1;
    else vlq_acc = {vlq_acc[24:0], b[6:0]};
    if (!b[7]) begin
      sum = ticks + vlq_acc;
      ticks = (sum < ticks) ? '1 : sum;
      ph = PH_EVENT;
    end else begin
      ph = PH_DELTA;
    end
  endtask

  // advance the mirrored parser by one byte, queueing any result it causes
  task automatic parse_byte(input logic [7:0] b);
    drum_event_t ev;
    logic [63:0] divisor;
    logic [63:0] quot;
    ev = '0;
    case (ph)
      PH_HDR: begin
        if (fld_cnt == HDR_TPQN_HI) tpqn = {b, 8'h00};
        else if (fld_cnt == HDR_TPQN_LO) tpqn = {tpqn[15:8], b};
        if (fld_cnt >= HDR_TPQN_LO) begin
          fld_cnt = 4'd0;
          ph = PH_SIG;
        end else begin
          fld_cnt = fld_cnt + 4'd1;
        end
      end
      PH_SIG: begin
        if (b != TRACK_TAG[8 * (3 - fld_cnt[1:0]) +: 8]) begin
          ev.kind = KIND_ERR;
          hits_due.push_back(ev);
          error_total++;
          ph = PH_HALT;
        end else if (fld_cnt >= FIELD_LAST) begin
          fld_cnt = 4'd0;
          trk_left = 32'd0;
          ph = PH_LEN;
        end else begin
          fld_cnt = fld_cnt + 4'd1;
        end
      end
      PH_LEN: begin
        trk_left = {trk_left[23:0], b};
        if (fld_cnt >= FIELD_LAST) begin
          fld_cnt = 4'd0;
          ticks = 32'd0;
          if (trk_left == 32'd0) ph = PH_SIG;
          else start_delta();
        end else begin
          fld_cnt = fld_cnt + 4'd1;
        end
      end
      PH_HALT: ;
      default: begin
        case (ph)
          PH_DELTA: take_vlq_byte(b);
          PH_EVENT: begin
            if (b == ST_META || b == ST_CTRL || b == ST_PROG || b == ST_NOTE_ON) begin
              run_status = b;
              if (b == ST_META) ph = PH_MTYPE;
              else if (b == ST_NOTE_ON) ph = PH_KEY;
              else ph = PH_CTRL1;
            end else if (run_status == ST_META) begin
              ph = PH_MLEN;
            end else if (run_status == ST_CTRL) begin
              ph = PH_CTRL2;
            end else if (run_status == ST_PROG) begin
              start_delta();
            end else if (run_status == ST_NOTE_ON) begin
              key_note = b;
              ph = PH_VEL;
            end else begin
              // no status seen yet: the byte opens a new delta time
              vlq_acc = 32'd0;
              take_vlq_byte(b);
            end
          end
          PH_MTYPE: ph = PH_MLEN;
          PH_MLEN: begin
            meta_left = b;
            if (b == 8'd0) start_delta();
            else ph = PH_MSKIP;
          end
          PH_MSKIP: begin
            meta_left = meta_left - 8'd1;
            if (meta_left == 8'd0) start_delta();
          end
          PH_CTRL1: begin
            if (run_status == ST_CTRL) ph = PH_CTRL2;
            else start_delta();
          end
          PH_CTRL2: start_delta();
          PH_KEY: begin
            key_note = b;
            ph = PH_VEL;
          end
          PH_VEL: begin
            if (b != 8'd0) begin
              divisor = 64'(tempo_now) * 64'(tpqn);
              if (divisor == 64'd0) begin
                quot = 64'hFFFF_FFFF;
              end else begin
                quot = 64'(ticks) * 64'(MS_PER_MINUTE) / divisor;
                if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
              end
              ev.kind = KIND_HIT;
              ev.code = drum_of(key_note);
              ev.note = key_note;
              ev.ms = quot[31:0];
              hits_due.push_back(ev);
              hit_total++;
              ticks = 32'd0;
            end
            start_delta();
          end
          default: ;
        endcase
        if (trk_left != 32'd0) trk_left = trk_left - 32'd1;
        if (trk_left == 32'd0) begin
          fld_cnt = 4'd0;
          ph = PH_SIG;
        end
      end
    endcase
  endtask

  // monitor: checks results, then advances the predictor on each byte transfer
  always @(posedge clk) begin
    byte_taken <= in_valid && in_ready;
    cfg_taken <= cfg_valid && cfg_ready;
    if (rst) begin
      ph = PH_HDR;
      fld_cnt = 4'd0;
      tpqn = 16'd0;
      trk_left = 32'd0;
      vlq_acc = 32'd0;
      ticks = 32'd0;
      run_status = 8'd0;
      meta_left = 8'd0;
      key_note = 8'd0;
      tempo_now = TEMPO_RESET;
    end else begin
      if (out_valid && out_ready) begin
        if (hits_due.size() == 0) begin
          $error("result with nothing expected: kind %0d note %0d", kind, note_number);
          mismatch_count++;
        end else begin
          want = hits_due.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            mismatch_count++;
          end
          if (drum_code !== want.code) begin
            $error("drum_code: expected %0d, got %0d", want.code, drum_code);
            mismatch_count++;
          end
          if (note_number !== want.note) begin
            $error("note_number: expected %0d, got %0d", want.note, note_number);
            mismatch_count++;
          end
          if (time_ms !== want.ms) begin
            $error("time_ms: expected %0d, got %0d", want.ms, time_ms);
            mismatch_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) tempo_now = cfg_data;
      if (in_valid && in_ready) begin
        parse_byte(data_byte);
        taken_total++;
      end
    end
  end

  // byte driver: bursts of random length with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !byte_taken) begin
      // hold until the transfer happens
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (byte_queue.size() > 0) begin
      in_valid <= 1'b1;
      data_byte <= byte_queue.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver: stall pattern switches between open, coin toss and long stalls
  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      mode_left <= $urandom_range(20, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
      default: begin
        if (stall_left > 0) begin
          out_ready <= 1'b0;
          stall_left <= stall_left - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) stall_left <= $urandom_range(1, 40);
        end
      end
    endcase
  end

  task automatic queue_byte(input logic [7:0] b);
    byte_queue.push_back(b);
    queued_total++;
  endtask

  // frame the first len bytes of track_body as one track
  task automatic emit_track(input int len);
    logic [31:0] lv;
    lv = 32'(len);
    for (int i = 3; i >= 0; i--) queue_byte(TRACK_TAG[8 * i +: 8]);
    for (int i = 3; i >= 0; i--) queue_byte(lv[8 * i +: 8]);
    for (int i = 0; i < len; i++) queue_byte(track_body[i]);
  endtask

  task automatic add_track();
    int n_events;
    int pick;
    int nb;
    int len;
    logic [31:0] dv;
    logic [7:0] rb;
    track_body.delete();
    n_events = $urandom_range(2, 24);
    repeat (n_events) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        // five-byte delta, which runs past 32 bits when its first byte is 16 or more
        rb = 8'($urandom_range(1, 127));
        track_body.push_back({1'b1, rb[6:0]});
        repeat (3) begin
          rb = 8'($urandom_range(0, 127));
          track_body.push_back({1'b1, rb[6:0]});
        end
        rb = 8'($urandom_range(0, 127));
        track_body.push_back({1'b0, rb[6:0]});
      end else begin
        if (pick < 12) dv = $urandom_range(0, 127);
        else if (pick < 17) dv = $urandom_range(128, 16383);
        else dv = $urandom_range(0, 32'h0FFF_FFFF);
        nb = 1;
        while (nb < 4 && (dv >> (7 * nb)) != 0) nb++;
        for (int i = nb - 1; i >= 0; i--) track_body.push_back({i != 0, dv[7 * i +: 7]});
      end

      pick = $urandom_range(0, 19);
      if (pick < 10 || pick >= 17) begin
        if (gen_status != ST_NOTE_ON || $urandom_range(0, 2) == 0)
          track_body.push_back(ST_NOTE_ON);
        gen_status = ST_NOTE_ON;
        nb = $urandom_range(0, 19);
        if (nb < 14) rb = 8'($urandom_range(35, 58));
        else if (nb < 19) rb = 8'($urandom_range(0, 127));
        else rb = 8'($urandom_range(128, 255));
        track_body.push_back(rb);
        nb = $urandom_range(0, 19);
        if (nb < 2) rb = 8'd0;
        else if (nb < 18) rb = 8'($urandom_range(1, 127));
        else rb = 8'($urandom_range(128, 255));
        track_body.push_back(rb);
      end else if (pick < 13) begin
        if (gen_status != ST_META || $urandom_range(0, 2) == 0)
          track_body.push_back(ST_META);
        gen_status = ST_META;
        rb = ($urandom_range(0, 4) == 0) ? 8'h2F : 8'($urandom_range(0, 127));
        track_body.push_back(rb);
        nb = $urandom_range(0, 29);
        if (nb < 3) len = 0;
        else if (nb < 29) len = $urandom_range(1, 6);
        else len = $urandom_range(100, 255);
        track_body.push_back(len[7:0]);
        repeat (len) begin
          rb = 8'($urandom_range(0, 255));
          track_body.push_back(rb);
        end
      end else if (pick < 14) begin
        if (gen_status != ST_CTRL || $urandom_range(0, 2) == 0)
          track_body.push_back(ST_CTRL);
        gen_status = ST_CTRL;
        repeat (2) begin
          rb = 8'($urandom_range(0, 127));
          track_body.push_back(rb);
        end
      end else if (pick < 15) begin
        if (gen_status != ST_PROG || $urandom_range(0, 2) == 0)
          track_body.push_back(ST_PROG);
        gen_status = ST_PROG;
        rb = 8'($urandom_range(0, 127));
        track_body.push_back(rb);
      end else begin
        // junk bytes, including stray status values
        repeat ($urandom_range(1, 4)) begin
          rb = 8'($urandom_range(0, 255));
          track_body.push_back(rb);
        end
      end
    end

    pick = $urandom_range(0, 15);
    if (pick == 0) len = 0;
    else if (pick < 3) len = $urandom_range(1, track_body.size());
    else len = track_body.size();
    emit_track(len);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (taken_total != queued_total || hits_due.size() != 0);
  endtask

  task automatic write_tempo(input logic [7:0] t);
    cfg_data <= t;
    cfg_valid <= 1'b1;
    do @(negedge clk);
    while (!cfg_taken);
    cfg_valid <= 1'b0;
    tempo_writes++;
  endtask

  initial begin
    int pick;
    int phase_no;
    int target;
    int k;
    logic [15:0] tq;
    logic [7:0] rb;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pick = $urandom_range(0, 7);
    if (pick == 0) tq = 16'd0;
    else if (pick < 4) tq = 16'($urandom_range(1, 32));
    else if (pick < 6) tq = 16'($urandom_range(33, 1000));
    else tq = 16'($urandom_range(1, 65535));

    // file header, run at the reset tempo
    queue_byte(8'h4D); queue_byte(8'h54); queue_byte(8'h68); queue_byte(8'h64);
    queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h00); queue_byte(8'h06);
    queue_byte(8'h00); queue_byte(8'h01); queue_byte(8'h00); queue_byte(8'h01);
    queue_byte(tq[15:8]); queue_byte(tq[7:0]);

    // directed track
    track_body.delete();
    // data byte before any status is read as a delta
    track_body.push_back(8'h00); track_body.push_back(8'h05);
    track_body.push_back(ST_NOTE_ON); track_body.push_back(8'd36); track_body.push_back(8'h64);
    // running status note-on with zero velocity keeps the tick total
    track_body.push_back(8'h81); track_body.push_back(8'h00);
    track_body.push_back(8'd38); track_body.push_back(8'h00);
    track_body.push_back(8'h00); track_body.push_back(ST_META);
    track_body.push_back(8'h2F); track_body.push_back(8'h00);
    track_body.push_back(8'h00); track_body.push_back(ST_CTRL);
    track_body.push_back(8'h07); track_body.push_back(8'h7F);
    track_body.push_back(8'h00); track_body.push_back(ST_PROG); track_body.push_back(8'h05);
    track_body.push_back(8'h00); track_body.push_back(ST_NOTE_ON);
    track_body.push_back(8'd200); track_body.push_back(8'h7F);
    // delta past 32 bits saturates
    repeat (4) track_body.push_back(8'hFF);
    track_body.push_back(8'h7F);
    track_body.push_back(ST_NOTE_ON); track_body.push_back(8'd42); track_body.push_back(8'hFF);
    emit_track(track_body.size());
    emit_track(0);
    gen_status = ST_NOTE_ON;

    phase_no = 1;
    while (queued_total < ITEM_GOAL) begin
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clk);
      if (phase_no == 1) write_tempo(8'd1);
      else if (phase_no == 2) write_tempo(8'd255);
      else write_tempo(8'($urandom_range(1, 255)));
      target = queued_total + $urandom_range(150, 260);
      while (queued_total < target) add_track();
      phase_no++;
    end

    // bad signature, then bytes the halted block must swallow
    k = $urandom_range(0, 3);
    for (int i = 0; i < k; i++) queue_byte(TRACK_TAG[8 * (3 - i) +: 8]);
    do rb = 8'($urandom_range(0, 255));
    while (rb == TRACK_TAG[8 * (3 - k) +: 8]);
    queue_byte(rb);
    repeat (12) begin
      rb = 8'($urandom_range(0, 255));
      queue_byte(rb);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("stream of %0d bytes gave %0d drum hits and %0d signature errors",
             taken_total, hit_total, error_total);
    $display("tempo settings used: %0d, ticks per quarter %0d", tempo_writes + 1, tq);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### midi_drum_track_parser.f
design/mdtp_pkg.sv
design/mdtp_front.sv
design/mdtp_queue.sv
design/mdtp_back.sv
design/midi_drum_track_parser.sv
tb/tb_midi_drum_track_parser.sv
